[rtl/bdlp_pkg.sv]
// ----------------------------------------------------------------------------
// bdlp_pkg
// Types and constants shared by the button debouncer with long-press detection
// ----------------------------------------------------------------------------
package bdlp_pkg;

  // default width of the millisecond time base
  localparam int TIME_WIDTH_DEF = 32;

  // configuration port geometry
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DEBOUNCE_MS   = 3'd0,
    CFG_LONG_PRESS_MS = 3'd1,
    CFG_GAP_MS        = 3'd2,
    CFG_PRESS_LIMIT   = 3'd3,
    CFG_ACTIVE_LEVEL  = 3'd4
  } cfg_index_t;

  // configuration reset values
  localparam logic [15:0] DEBOUNCE_MS_RST   = 16'd50;
  localparam logic [15:0] LONG_PRESS_MS_RST = 16'd1000;
  localparam logic [15:0] GAP_MS_RST        = 16'd500;
  localparam logic [6:0]  PRESS_LIMIT_RST   = 7'd3;
  localparam logic        ACTIVE_LEVEL_RST  = 1'b0;

  // confirmed button state
  typedef enum logic [1:0] {
    ST_RELEASED = 2'd0,
    ST_PRESSED  = 2'd1,
    ST_LONG     = 2'd2
  } btn_state_t;

  // reported event codes
  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_PRESS      = 3'd1,
    EV_LONG       = 3'd2,
    EV_RELEASE    = 3'd3,
    EV_RELEASE_LP = 3'd4
  } evt_code_t;

  // one pin sample
  typedef struct packed {
    logic        pin_level;
    logic [31:0] now_ms;
    logic        learn_mode;
  } in_item_t;

  // one result
  typedef struct packed {
    evt_code_t  event_res;
    logic [6:0] press_count;
    btn_state_t stable_state;
  } out_item_t;

endpackage

[rtl/button_debounce_long_press.sv]
// ----------------------------------------------------------------------------
// button_debounce_long_press
// Button debouncer with long-press detection and press/release event reports
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one pin sample per transaction (pin level, millisecond timestamp,
//           learn mode flag). Accepted when in_valid is high and in_stall low.
//   out_* : exactly one result per sample (event code, press count, confirmed
//           state), taken when out_valid is high and out_stall low.
//   cfg_* : register writes (debounce, long press, gap, press limit, active
//           level), to be done by the user only while idle; the block does not enforce it.
// Timing:
//   a sample lands in the input register, is evaluated against the debounce
//   state while it is held there and is written to the result register on
//   out_* once that register is free. One sample per cycle is sustained
//   while out_stall is low; the state update is a single subtract and compare
//   on the time base, so nothing limits the rate but the receiver.
// Stall:
//   when out_stall holds a result, the input register keeps its sample and
//   in_stall rises only once that register is occupied.
// Reset:
//   rst_n (synchronous, active low) empties both registers, restores the
//   register defaults and returns the button to released with a zero count.
// ----------------------------------------------------------------------------
module button_debounce_long_press
  import bdlp_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // sample channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data,
  // configuration
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  // configuration registers
  logic [15:0] debounce_ms_r;
  logic [15:0] long_press_ms_r;
  logic [15:0] gap_ms_r;
  logic [6:0]  press_limit_r;
  logic        active_level_r;

  // pipeline registers
  logic      in_valid_r;
  in_item_t  in_data_r;
  logic      out_valid_r;
  out_item_t out_data_r;

  // button state
  logic                  pending_r, pending_nxt;
  btn_state_t            conf_r, conf_nxt;
  btn_state_t            rep_r, rep_nxt;
  logic [7:0]            tcount_r, tcount_nxt;
  logic [TIME_WIDTH-1:0] evt_time_r, evt_time_nxt;

  // evaluation signals
  logic                  out_free;
  logic                  advance;
  logic                  pressed;
  btn_state_t            sample_st;
  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] diff;
  logic                  deb_wait;
  logic                  lp_done;
  logic                  gap_done;
  logic [7:0]            tc_scan;
  btn_state_t            conf_scan;
  out_item_t             res;

  // handshake
  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = in_valid_r && out_free;
  assign in_stall  = in_valid_r && !out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ms_r   <= DEBOUNCE_MS_RST;
      long_press_ms_r <= LONG_PRESS_MS_RST;
      gap_ms_r        <= GAP_MS_RST;
      press_limit_r   <= PRESS_LIMIT_RST;
      active_level_r  <= ACTIVE_LEVEL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE_MS:   debounce_ms_r   <= cfg_wdata;
        CFG_LONG_PRESS_MS: long_press_ms_r <= cfg_wdata;
        CFG_GAP_MS:        gap_ms_r        <= cfg_wdata;
        CFG_PRESS_LIMIT:   press_limit_r   <= cfg_wdata[6:0];
        CFG_ACTIVE_LEVEL:  active_level_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // time differences and thresholds
  assign pressed   = (in_data_r.pin_level == active_level_r);
  assign sample_st = pressed ? ST_PRESSED : ST_RELEASED;
  assign now_t     = TIME_WIDTH'(in_data_r.now_ms);
  assign diff      = now_t - evt_time_r;
  assign deb_wait  = pending_r && (diff < TIME_WIDTH'(debounce_ms_r));
  assign lp_done   = (diff >= TIME_WIDTH'(long_press_ms_r));
  assign gap_done  = (diff >= TIME_WIDTH'(gap_ms_r));

  // debounce scan and event reporting for one sample
  always_comb begin
    pending_nxt  = pending_r;
    evt_time_nxt = evt_time_r;
    conf_scan    = conf_r;
    tc_scan      = tcount_r;
    tcount_nxt   = tcount_r;
    rep_nxt      = rep_r;
    res          = '{event_res: EV_NONE, press_count: 7'd0, stable_state: ST_RELEASED};

    // scan: qualify the sample against the confirmed state
    if (deb_wait) begin
      // still inside the debounce wait
    end else if (pressed && conf_r == ST_LONG) begin
      // held long press
    end else if (sample_st == conf_r) begin
      if (pending_r) begin
        pending_nxt = 1'b0;
      end else if (pressed && lp_done) begin
        conf_scan = ST_LONG;
      end else if (!pressed && gap_done) begin
        tc_scan = 8'd0;
      end
    end else if (!pending_r) begin
      evt_time_nxt = now_t;
      pending_nxt  = 1'b1;
    end else begin
      pending_nxt = 1'b0;
      conf_scan   = sample_st;
      tc_scan     = tcount_r + 8'd1;
    end

    // report: one event per change of the confirmed state, none in learn mode
    tcount_nxt = tc_scan;
    if (conf_scan != rep_r && !in_data_r.learn_mode) begin
      case (conf_scan)
        ST_LONG:    res.event_res = EV_LONG;
        ST_PRESSED: res.event_res = EV_PRESS;
        default: begin
          if (rep_r == ST_LONG) begin
            tcount_nxt    = 8'd0;
            res.event_res = EV_RELEASE_LP;
          end else begin
            if (rep_r == ST_PRESSED && tc_scan > {press_limit_r, 1'b0}) begin
              tcount_nxt = 8'd2;
            end
            res.event_res = EV_RELEASE;
          end
          res.press_count = tcount_nxt[7:1];
        end
      endcase
      rep_nxt = conf_scan;
    end

    conf_nxt         = conf_scan;
    res.stable_state = conf_scan;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res;
    end
  end

  // button state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r  <= 1'b0;
      conf_r     <= ST_RELEASED;
      rep_r      <= ST_RELEASED;
      tcount_r   <= 8'd0;
      evt_time_r <= '0;
    end else if (advance) begin
      pending_r  <= pending_nxt;
      conf_r     <= conf_nxt;
      rep_r      <= rep_nxt;
      tcount_r   <= tcount_nxt;
      evt_time_r <= evt_time_nxt;
    end
  end

`ifndef SYNTHESIS
  // input side only stalls while a result is held back
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_valid_r && out_valid_r && out_stall))
    else $error("in_stall without a held result");

  // a press event reports the pressed state
  a_press_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.event_res == EV_PRESS) |->
      (out_data_r.stable_state == ST_PRESSED))
    else $error("press event with wrong stable state");

  // a count is reported only with a release
  a_count_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.press_count != 7'd0) |->
      (out_data_r.event_res == EV_RELEASE || out_data_r.event_res == EV_RELEASE_LP))
    else $error("press count outside a release event");

  // long press is reached only from a confirmed press
  a_long_from_press: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && conf_r == ST_LONG && $past(conf_r) != ST_LONG) |->
      ($past(conf_r) == ST_PRESSED))
    else $error("long press entered from release");

  // state only moves when a sample is evaluated
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!advance) |=> ($stable(conf_r) && $stable(tcount_r) && $stable(pending_r)))
    else $error("button state changed without a sample");
`endif

endmodule
